// File: rtl/nrmc_pkg.sv
`default_nettype none

package nrmc_pkg;

	// sentence framing
	localparam int BODY_MAX    = 80;
	localparam int HDR_LEN     = 7;
	localparam int FIELD_SLOTS = 12;

	// number scaling and saturation
	localparam int FRAC_DIGITS = 4;
	localparam int MAG_CAP     = 999999999;
	localparam int MAG_W       = $clog2(MAG_CAP + 1);
	localparam int POS_W       = 31;
	localparam int FRAC_W      = (FRAC_DIGITS > 0) ? $clog2(FRAC_DIGITS + 1) : 1;

	// counter widths
	localparam int BODY_W = $clog2(BODY_MAX);
	localparam int FIDX_W = 4;
	localparam int FLEN_W = 5;
	localparam int FLEN_MAX = 31;

	// field numbers of interest
	localparam logic [FIDX_W-1:0] FIELD_STATUS = 4'd1;
	localparam logic [FIDX_W-1:0] FIELD_LAT    = 4'd2;
	localparam logic [FIDX_W-1:0] FIELD_NS     = 4'd3;
	localparam logic [FIDX_W-1:0] FIELD_LON    = 4'd4;
	localparam logic [FIDX_W-1:0] FIELD_EW     = 4'd5;
	localparam logic [FIDX_W-1:0] FIELD_DEAD   = 4'd15;

	// characters
	localparam logic [7:0] CH_DOLLAR = "$";
	localparam logic [7:0] CH_G      = "G";
	localparam logic [7:0] CH_P      = "P";
	localparam logic [7:0] CH_R      = "R";
	localparam logic [7:0] CH_M      = "M";
	localparam logic [7:0] CH_C      = "C";
	localparam logic [7:0] CH_COMMA  = ",";
	localparam logic [7:0] CH_STAR   = "*";
	localparam logic [7:0] CH_A      = "A";
	localparam logic [7:0] CH_N      = "N";
	localparam logic [7:0] CH_E      = "E";
	localparam logic [7:0] CH_PLUS   = "+";
	localparam logic [7:0] CH_MINUS  = "-";
	localparam logic [7:0] CH_DOT    = ".";
	localparam logic [7:0] CH_0      = "0";
	localparam logic [7:0] CH_9      = "9";
	localparam logic [7:0] CH_SPACE  = " ";
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_NUL    = 8'h00;

	// power of ten at elaboration
	function automatic longint pow10_f(input int n);
		longint p;
		p = 1;
		for (int i = 0; i < n; i++) begin
			p = p * 10;
		end
		return p;
	endfunction

	localparam longint POW_MAX = pow10_f(FRAC_DIGITS);
	localparam int     POW_W   = $clog2(POW_MAX + 1);
	localparam int     PROD_W  = MAG_W + POW_W;

	// one coordinate as parsed: digits, fraction digits taken, minus sign
	typedef struct packed {
		logic [MAG_W-1:0]  accum;
		logic [FRAC_W-1:0] frac;
		logic              neg;
	} coord_raw_t;

	// everything the result path needs at the end of a sentence
	typedef struct packed {
		logic       status;
		coord_raw_t lat;
		coord_raw_t lon;
		logic       north;
		logic       east;
	} rmc_req_t;

endpackage

`default_nettype wire

// File: rtl/nmea_rmc_position_parser.sv
`default_nettype none

// Byte-stream parser for "$GPRMC," sentences. One byte is taken per clock; in_ready
// only drops when a finished word is stuck behind a stalled output and another
// sentence end is already waiting. The header is matched byte by byte, a mismatch
// restarts the hunt with the next byte. Body fields are split at commas with empty
// fields skipped; '*' closes the sentence and gives one output word, which passes
// through the end register, the scale stage with its multiplier and the output
// register. When the status field is exactly "A" the stored latitude and
// longitude are replaced from fields 2 to 5, scaled by 10^FRAC_DIGITS, truncated and
// saturated at 999999999; otherwise the previous position is repeated.
module nmea_rmc_position_parser (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [7:0]    rx_byte,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic               fix_valid,
	output logic signed [30:0] latitude,
	output logic signed [30:0] longitude
);
	import nrmc_pkg::*;

	// expected header character at each position
	function automatic logic [7:0] hdr_char_f(input logic [2:0] pos);
		logic [7:0] c;
		case (pos)
			3'd0:    c = CH_DOLLAR;
			3'd1:    c = CH_G;
			3'd2:    c = CH_P;
			3'd3:    c = CH_R;
			3'd4:    c = CH_M;
			3'd5:    c = CH_C;
			3'd6:    c = CH_COMMA;
			default: c = CH_STAR;
		endcase
		return c;
	endfunction

	// one more integer or fraction digit, saturating
	function automatic logic [MAG_W-1:0] acc_digit_f(input logic [MAG_W-1:0] acc,
			input logic [3:0] d);
		logic [MAG_W+3:0] t;
		t = (MAG_W + 4)'(acc) * (MAG_W + 4)'(10) + (MAG_W + 4)'(d);
		return (t > (MAG_W + 4)'(MAG_CAP)) ? MAG_W'(MAG_CAP) : t[MAG_W-1:0];
	endfunction

	// parser state
	logic [2:0]        header_pos_q, header_pos_d;
	logic              in_body_q, in_body_d;
	logic [BODY_W-1:0] body_count_q, body_count_d;
	logic [FIDX_W-1:0] field_index_q, field_index_d;
	logic [FLEN_W-1:0] field_length_q, field_length_d;
	logic              status_is_a_q, status_is_a_d;
	logic              north_flag_q, north_flag_d;
	logic              east_flag_q, east_flag_d;
	logic [MAG_W-1:0]  accum_q, accum_d;
	logic [FRAC_W-1:0] frac_q, frac_d;
	logic              dot_seen_q, dot_seen_d;
	logic              stopped_q, stopped_d;
	logic              started_q, started_d;
	logic              negative_q, negative_d;
	coord_raw_t        lat_q, lat_d;
	coord_raw_t        lon_q, lon_d;

	// sentence end register
	logic              r1_v_s1;
	rmc_req_t          req_s1, req_d;
	logic              req_load;
	logic              req_ready;

	// number step working values
	logic [MAG_W-1:0]  e_accum;
	logic [FRAC_W-1:0] e_frac;
	logic              e_dot, e_stopped, e_started, e_negative;
	logic [MAG_W-1:0]  n_accum;
	logic [FRAC_W-1:0] n_frac;
	logic              n_dot, n_stopped, n_started, n_negative;
	logic              is_digit, is_space, first_char, accept;
	coord_raw_t        cur_num;

	assign accept     = in_valid && in_ready;
	assign in_ready   = !r1_v_s1 || req_ready;
	assign first_char = (field_length_q == '0);
	assign is_digit   = (rx_byte >= CH_0) && (rx_byte <= CH_9);
	assign is_space   = (rx_byte == CH_SPACE) || ((rx_byte >= CH_TAB) && (rx_byte <= CH_CR));
	assign cur_num    = '{accum: accum_q, frac: frac_q, neg: negative_q};

	// number reader: state as seen by this character, then one step
	always_comb begin
		e_accum    = first_char ? '0 : accum_q;
		e_frac     = first_char ? '0 : frac_q;
		e_dot      = first_char ? 1'b0 : dot_seen_q;
		e_stopped  = first_char ? 1'b0 : stopped_q;
		e_started  = first_char ? 1'b0 : started_q;
		e_negative = first_char ? 1'b0 : negative_q;
		n_accum    = e_accum;
		n_frac     = e_frac;
		n_dot      = e_dot;
		n_stopped  = e_stopped;
		n_started  = e_started;
		n_negative = e_negative;
		if (e_stopped) begin
			n_stopped = 1'b1;
		end else if (!e_started && is_space) begin
			n_started = 1'b0;
		end else if (!e_started && ((rx_byte == CH_PLUS) || (rx_byte == CH_MINUS))) begin
			n_started  = 1'b1;
			n_negative = (rx_byte == CH_MINUS);
		end else if (is_digit) begin
			n_started = 1'b1;
			if (!e_dot) begin
				n_accum = acc_digit_f(e_accum, 4'(rx_byte - CH_0));
			end else if (e_frac < FRAC_W'(FRAC_DIGITS)) begin
				n_accum = acc_digit_f(e_accum, 4'(rx_byte - CH_0));
				n_frac  = e_frac + FRAC_W'(1);
			end
		end else if ((rx_byte == CH_DOT) && !e_dot) begin
			n_started = 1'b1;
			n_dot     = 1'b1;
		end else begin
			n_stopped = 1'b1;
		end
	end

	// header hunt and body fields
	always_comb begin
		header_pos_d   = header_pos_q;
		in_body_d      = in_body_q;
		body_count_d   = body_count_q;
		field_index_d  = field_index_q;
		field_length_d = field_length_q;
		status_is_a_d  = status_is_a_q;
		north_flag_d   = north_flag_q;
		east_flag_d    = east_flag_q;
		accum_d        = accum_q;
		frac_d         = frac_q;
		dot_seen_d     = dot_seen_q;
		stopped_d      = stopped_q;
		started_d      = started_q;
		negative_d     = negative_q;
		lat_d          = lat_q;
		lon_d          = lon_q;
		req_load       = 1'b0;
		req_d          = req_s1;

		if (accept) begin
			if (!in_body_q) begin
				if (rx_byte == hdr_char_f(header_pos_q)) begin
					if (header_pos_q == 3'(HDR_LEN - 1)) begin
						header_pos_d   = '0;
						in_body_d      = 1'b1;
						body_count_d   = '0;
						field_index_d  = '0;
						field_length_d = '0;
					end else begin
						header_pos_d = header_pos_q + 3'd1;
					end
				end else begin
					header_pos_d = '0;
				end
			end else if (rx_byte == CH_STAR) begin
				// sentence end: '*' is the last character of the open field
				in_body_d    = 1'b0;
				header_pos_d = '0;
				if (field_index_q < FIDX_W'(FIELD_SLOTS)) begin
					case (field_index_q)
						FIELD_STATUS: status_is_a_d = 1'b0;
						FIELD_NS:     north_flag_d  = 1'b0;
						FIELD_EW:     east_flag_d   = 1'b0;
						FIELD_LAT:    lat_d = first_char ? '0 : cur_num;
						FIELD_LON:    lon_d = first_char ? '0 : cur_num;
						default:      ;
					endcase
				end
				req_load = 1'b1;
				req_d    = '{status: status_is_a_d, lat: lat_d, lon: lon_d,
					north: north_flag_d, east: east_flag_d};
			end else if (body_count_q < BODY_W'(BODY_MAX - 1)) begin
				body_count_d = body_count_q + BODY_W'(1);
				if (field_index_q < FIDX_W'(FIELD_SLOTS)) begin
					if ((rx_byte == CH_NUL) || (rx_byte == CH_COMMA)) begin
						// close a non-empty field
						if (!first_char) begin
							if (field_index_q == FIELD_LAT) begin
								lat_d = cur_num;
							end
							if (field_index_q == FIELD_LON) begin
								lon_d = cur_num;
							end
						end
						if (rx_byte == CH_NUL) begin
							field_index_d  = FIELD_DEAD;
							field_length_d = '0;
						end else if (!first_char) begin
							field_index_d  = field_index_q + FIDX_W'(1);
							field_length_d = '0;
						end
					end else begin
						// field character
						if (field_length_q != FLEN_W'(FLEN_MAX)) begin
							field_length_d = field_length_q + FLEN_W'(1);
						end
						case (field_index_q)
							FIELD_STATUS: status_is_a_d = first_char && (rx_byte == CH_A);
							FIELD_NS:     north_flag_d  = first_char && (rx_byte == CH_N);
							FIELD_EW:     east_flag_d   = first_char && (rx_byte == CH_E);
							FIELD_LAT, FIELD_LON: begin
								accum_d    = n_accum;
								frac_d     = n_frac;
								dot_seen_d = n_dot;
								stopped_d  = n_stopped;
								started_d  = n_started;
								negative_d = n_negative;
							end
							default: ;
						endcase
					end
				end
			end
		end
	end

	// parser registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_pos_q   <= '0;
			in_body_q      <= 1'b0;
			body_count_q   <= '0;
			field_index_q  <= '0;
			field_length_q <= '0;
			status_is_a_q  <= 1'b0;
			north_flag_q   <= 1'b0;
			east_flag_q    <= 1'b0;
			accum_q        <= '0;
			frac_q         <= '0;
			dot_seen_q     <= 1'b0;
			stopped_q      <= 1'b0;
			started_q      <= 1'b0;
			negative_q     <= 1'b0;
			lat_q          <= '0;
			lon_q          <= '0;
			r1_v_s1        <= 1'b0;
		end else begin
			header_pos_q   <= header_pos_d;
			in_body_q      <= in_body_d;
			body_count_q   <= body_count_d;
			field_index_q  <= field_index_d;
			field_length_q <= field_length_d;
			status_is_a_q  <= status_is_a_d;
			north_flag_q   <= north_flag_d;
			east_flag_q    <= east_flag_d;
			accum_q        <= accum_d;
			frac_q         <= frac_d;
			dot_seen_q     <= dot_seen_d;
			stopped_q      <= stopped_d;
			started_q      <= started_d;
			negative_q     <= negative_d;
			lat_q          <= lat_d;
			lon_q          <= lon_d;
			r1_v_s1        <= req_load || (r1_v_s1 && !req_ready);
		end
	end

	// sentence end payload
	always_ff @(posedge clk) begin
		if (req_load) begin
			req_s1 <= req_d;
		end
	end

	// scaling, sign and output word
	nrmc_result u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_s1),
		.req_valid (r1_v_s1),
		.req_ready (req_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.fix_valid (fix_valid),
		.latitude  (latitude),
		.longitude (longitude)
	);

	// checks
	a_hdr_clear_in_body: assert property (@(posedge clk) disable iff (!arst_n)
		in_body_q |-> (header_pos_q == '0))
		else $error("header position left non-zero inside a body");

	a_body_bound: assert property (@(posedge clk) disable iff (!arst_n)
		body_count_q <= BODY_W'(BODY_MAX - 1))
		else $error("body counter past its limit");

	a_field_index: assert property (@(posedge clk) disable iff (!arst_n)
		(field_index_q <= FIDX_W'(FIELD_SLOTS)) || (field_index_q == FIELD_DEAD))
		else $error("field index out of range");

	a_star_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_body_q && (rx_byte == CH_STAR)) |=> r1_v_s1)
		else $error("sentence end did not raise a result request");

endmodule

`default_nettype wire

// File: rtl/nrmc_result.sv
`default_nettype none

module nrmc_result (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire nrmc_pkg::rmc_req_t req,
	input  wire logic              req_valid,
	output logic                   req_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   fix_valid,
	output logic signed [30:0]     latitude,
	output logic signed [30:0]     longitude
);
	import nrmc_pkg::*;

	// multiplier for the fraction digits still missing
	function automatic logic [POW_W-1:0] scale_f(input logic [FRAC_W-1:0] frac);
		longint p;
		p = 1;
		for (int i = 0; i < FRAC_DIGITS; i++) begin
			if (FRAC_W'(i) >= frac) begin
				p = p * 10;
			end
		end
		return POW_W'(p);
	endfunction

	// saturating scale of one coordinate
	function automatic logic [MAG_W-1:0] mag_f(input coord_raw_t c);
		logic [PROD_W-1:0] prod;
		prod = PROD_W'(c.accum) * PROD_W'(scale_f(c.frac));
		return (prod > PROD_W'(MAG_CAP)) ? MAG_W'(MAG_CAP) : prod[MAG_W-1:0];
	endfunction

	// two's complement pattern of a signed magnitude
	function automatic logic [POS_W-1:0] pattern_f(input logic [MAG_W-1:0] mag,
			input logic neg);
		logic [POS_W-1:0] m;
		m = POS_W'(mag);
		return neg ? (POS_W'(0) - m) : m;
	endfunction

	logic             s2_v_s2;
	logic             status_s2;
	logic [MAG_W-1:0] lat_mag_s2;
	logic [MAG_W-1:0] lon_mag_s2;
	logic             lat_neg_s2;
	logic             lon_neg_s2;
	logic             out_v_q;
	logic             fix_valid_q;
	logic [POS_W-1:0] stored_lat_q;
	logic [POS_W-1:0] stored_lon_q;
	logic             s2_adv;
	logic             req_take;

	// stage handshake
	assign s2_adv    = !out_v_q || out_ready;
	assign req_ready = !s2_v_s2 || s2_adv;
	assign req_take  = req_valid && req_ready;

	// scale stage: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v_s2 <= 1'b0;
		end else begin
			s2_v_s2 <= req_take || (s2_v_s2 && !s2_adv);
		end
	end

	// scale stage: magnitudes and hemisphere signs
	always_ff @(posedge clk) begin
		if (req_take) begin
			status_s2  <= req.status;
			lat_mag_s2 <= mag_f(req.lat);
			lon_mag_s2 <= mag_f(req.lon);
			lat_neg_s2 <= req.lat.neg ^ !req.north;
			lon_neg_s2 <= req.lon.neg ^ !req.east;
		end
	end

	// output word and stored position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q      <= 1'b0;
			fix_valid_q  <= 1'b0;
			stored_lat_q <= '0;
			stored_lon_q <= '0;
		end else begin
			out_v_q <= (s2_v_s2 && s2_adv) || (out_v_q && !out_ready);
			if (s2_v_s2 && s2_adv) begin
				fix_valid_q <= status_s2;
				if (status_s2) begin
					stored_lat_q <= pattern_f(lat_mag_s2, lat_neg_s2);
					stored_lon_q <= pattern_f(lon_mag_s2, lon_neg_s2);
				end
			end
		end
	end

	assign out_valid = out_v_q;
	assign fix_valid = fix_valid_q;
	assign latitude  = stored_lat_q;
	assign longitude = stored_lon_q;

endmodule

`default_nettype wire

// File: tb/sv/nmea_rmc_position_checker.sv
`default_nettype none

module nmea_rmc_position_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_ready,
	input  wire logic [7:0]         rx_byte,
	input  wire logic               out_valid,
	input  wire logic               out_ready,
	input  wire logic               fix_valid,
	input  wire logic signed [30:0] latitude,
	input  wire logic signed [30:0] longitude,
	output int                      fault_count,
	output int                      pending_words
);

	timeunit 1ns;
	timeprecision 1ps;

	import nrmc_pkg::*;

	localparam logic [8*HDR_LEN-1:0] HDR_TEXT = {CH_DOLLAR, CH_G, CH_P, CH_R, CH_M, CH_C,
		CH_COMMA};

	typedef struct packed {
		logic                    fix;
		logic signed [POS_W-1:0] lat;
		logic signed [POS_W-1:0] lon;
	} fix_word_t;

	// words still owed by the parser, oldest first
	fix_word_t fix_words[$];
	fix_word_t want;
	int faults = 0;

	// sentence framing state
	logic [2:0]        hdr_pos;
	logic              in_sentence;
	logic [BODY_W-1:0] body_taken;
	logic [FIDX_W-1:0] fld_idx;
	logic [FLEN_W-1:0] fld_len;
	logic              status_a, north, east;

	// number reader state
	logic [MAG_W-1:0]  acc;
	logic [FRAC_W-1:0] frac_taken;
	logic              dot, stopped, started, minus;

	// coordinates as parsed and as last stored
	logic [MAG_W-1:0]  lat_mag, lon_mag;
	logic              lat_minus, lon_minus;
	logic [POS_W-1:0]  pos_lat, pos_lon;

	function automatic logic [MAG_W-1:0] cap_mag(input longint v);
		return (v > MAG_CAP) ? MAG_W'(MAG_CAP) : v[MAG_W-1:0];
	endfunction

	// accumulated digits scaled up to the full number of fraction places
	function automatic logic [MAG_W-1:0] scaled_mag();
		longint m;
		m = longint'(acc);
		for (int k = frac_taken; k < FRAC_DIGITS; k++) begin
			m = longint'(cap_mag(m * 10));
		end
		return m[MAG_W-1:0];
	endfunction

	function automatic logic [POS_W-1:0] signed_pos(input logic [MAG_W-1:0] mag,
		input logic neg);
		logic [POS_W-1:0] m;
		m = POS_W'(mag);
		return neg ? -m : m;
	endfunction

	// one character of a coordinate field, read like atof
	function automatic void number_char(input logic [7:0] c);
		logic space;
		space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
		if (stopped || (!started && space)) begin
			return;
		end
		if (!started && (c == CH_PLUS || c == CH_MINUS)) begin
			started = 1'b1;
			minus = (c == CH_MINUS);
		end else if (c >= CH_0 && c <= CH_9) begin
			started = 1'b1;
			if (!dot) begin
				acc = cap_mag(longint'(acc) * 10 + (c - CH_0));
			end else if (frac_taken < FRAC_DIGITS) begin
				acc = cap_mag(longint'(acc) * 10 + (c - CH_0));
				frac_taken++;
			end
		end else if (c == CH_DOT && !dot) begin
			started = 1'b1;
			dot = 1'b1;
		end else begin
			stopped = 1'b1;
		end
	endfunction

	// one character inside a non-empty field
	function automatic void field_char(input logic [7:0] c);
		if (fld_idx >= FIELD_SLOTS) begin
			return;
		end
		if (fld_len == 0) begin
			acc = '0;
			frac_taken = '0;
			dot = 1'b0;
			stopped = 1'b0;
			started = 1'b0;
			minus = 1'b0;
		end
		if (fld_len < FLEN_MAX) begin
			fld_len++;
		end
		case (fld_idx)
			FIELD_STATUS: status_a = (fld_len == 1 && c == CH_A);
			FIELD_NS:     north = (fld_len == 1 && c == CH_N);
			FIELD_EW:     east = (fld_len == 1 && c == CH_E);
			FIELD_LAT, FIELD_LON: number_char(c);
			default: ;
		endcase
	endfunction

	function automatic void close_field();
		if (fld_len == 0) begin
			return;
		end
		if (fld_idx == FIELD_LAT) begin
			lat_mag = scaled_mag();
			lat_minus = minus;
		end else if (fld_idx == FIELD_LON) begin
			lon_mag = scaled_mag();
			lon_minus = minus;
		end
	endfunction

	// advance the prediction by one accepted byte
	function automatic void absorb_byte(input logic [7:0] c);
		fix_word_t w;
		if (!in_sentence) begin
			if (hdr_pos < HDR_LEN && c == HDR_TEXT[8*(HDR_LEN-1-hdr_pos) +: 8]) begin
				hdr_pos++;
				if (hdr_pos == HDR_LEN) begin
					hdr_pos = '0;
					in_sentence = 1'b1;
					body_taken = '0;
					fld_idx = '0;
					fld_len = '0;
				end
			end else begin
				hdr_pos = '0;
			end
			return;
		end
		// a star always closes the sentence and gives one word
		if (c == CH_STAR) begin
			field_char(c);
			if (fld_idx < FIELD_SLOTS) begin
				close_field();
			end
			if (status_a) begin
				pos_lat = signed_pos(lat_mag, lat_minus ^ !north);
				pos_lon = signed_pos(lon_mag, lon_minus ^ !east);
			end
			w.fix = status_a;
			w.lat = pos_lat;
			w.lon = pos_lon;
			fix_words.push_back(w);
			in_sentence = 1'b0;
			hdr_pos = '0;
			return;
		end
		// body full: drop everything but the star
		if (body_taken >= BODY_MAX - 1) begin
			return;
		end
		body_taken++;
		if (fld_idx >= FIELD_SLOTS) begin
			return;
		end
		if (c == CH_NUL) begin
			close_field();
			fld_idx = FIELD_DEAD;
			fld_len = '0;
		end else if (c == CH_COMMA) begin
			if (fld_len > 0) begin
				close_field();
				if (fld_idx < FIELD_DEAD) begin
					fld_idx++;
				end
				fld_len = '0;
			end
		end else begin
			field_char(c);
		end
	endfunction

	task automatic note_fault(input string what);
		if (faults < 10) begin
			$display("%s", what);
		end
		faults++;
	endtask

	// compare outgoing words, then predict from incoming words
	always @(posedge clk) begin
		if (!arst_n) begin
			hdr_pos = '0;
			in_sentence = 1'b0;
			body_taken = '0;
			fld_idx = '0;
			fld_len = '0;
			status_a = 1'b0;
			north = 1'b0;
			east = 1'b0;
			acc = '0;
			frac_taken = '0;
			dot = 1'b0;
			stopped = 1'b0;
			started = 1'b0;
			minus = 1'b0;
			lat_mag = '0;
			lon_mag = '0;
			lat_minus = 1'b0;
			lon_minus = 1'b0;
			pos_lat = '0;
			pos_lon = '0;
			fix_words.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (fix_words.size() == 0) begin
					note_fault($sformatf("unexpected word: fix %0b lat %0d lon %0d",
						fix_valid, latitude, longitude));
				end else begin
					want = fix_words.pop_front();
					if (fix_valid !== want.fix || latitude !== want.lat
						|| longitude !== want.lon) begin
						note_fault($sformatf({"word mismatch: expected fix %0b lat %0d lon %0d,",
							" got fix %0b lat %0d lon %0d"}, want.fix, want.lat, want.lon,
							fix_valid, latitude, longitude));
					end
				end
			end
			if (in_valid && in_ready) begin
				absorb_byte(rx_byte);
			end
		end
		pending_words <= fix_words.size();
		fault_count <= faults;
	end

endmodule

`default_nettype wire

// File: tb/sv/nmea_rmc_position_parser_test.sv
`default_nettype none

module nmea_rmc_position_parser_test;

	timeunit 1ns;
	timeprecision 1ps;

	import nrmc_pkg::*;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [7:0]         rx_byte = 8'h00;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               fix_valid;
	logic signed [30:0] latitude;
	logic signed [30:0] longitude;
	int                 fault_count;
	int                 pending_words;

	// idle odds in percent for each side
	int send_idle = 23;
	int recv_idle = 73;

	// bytes of the line being built
	logic [7:0] line_q[$];

	nmea_rmc_position_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_byte   (rx_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.fix_valid (fix_valid),
		.latitude  (latitude),
		.longitude (longitude)
	);

	nmea_rmc_position_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.fix_valid     (fix_valid),
		.latitude      (latitude),
		.longitude     (longitude),
		.fault_count   (fault_count),
		.pending_words (pending_words)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// receiver stalls at random
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	// hand one byte over, with random idle cycles in front of it
	task automatic push_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic send_line();
		for (int i = 0; i < line_q.size(); i++) begin
			push_byte(line_q[i]);
		end
		line_q.delete();
	endtask

	// hold off until every word owed has come out
	task automatic drain_words();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_words != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			line_q.push_back(s[i]);
		end
	endfunction

	function automatic void add_run(input logic [7:0] ch, input int n);
		for (int i = 0; i < n; i++) begin
			line_q.push_back(ch);
		end
	endfunction

	function automatic void add_digits(input int n);
		for (int i = 0; i < n; i++) begin
			line_q.push_back(8'(CH_0 + $urandom_range(9)));
		end
	endfunction

	// coordinate text: optional blank, sign, digits, fraction, stray tail
	function automatic void add_number();
		if ($urandom_range(99) < 8) begin
			case ($urandom_range(2))
				0: line_q.push_back(CH_SPACE);
				1: line_q.push_back(CH_TAB);
				default: line_q.push_back(CH_CR);
			endcase
		end
		case ($urandom_range(99)) inside
			[0:14]:  line_q.push_back(CH_MINUS);
			[15:21]: line_q.push_back(CH_PLUS);
			default: ;
		endcase
		add_digits(($urandom_range(99) < 5) ? $urandom_range(6, 14) : $urandom_range(0, 5));
		if ($urandom_range(99) < 85) begin
			line_q.push_back(CH_DOT);
			add_digits($urandom_range(0, 7));
		end
		if ($urandom_range(99) < 8) begin
			line_q.push_back(8'($urandom_range(33, 126)));
		end
	endfunction

	// one-letter flag field: mostly the hit letter or its opposite
	function automatic void add_flag(input logic [7:0] hit, input logic [7:0] other);
		case ($urandom_range(99)) inside
			[0:44]:  line_q.push_back(hit);
			[45:84]: line_q.push_back(other);
			[85:92]: add_run(hit, 2);
			default: line_q.push_back(8'($urandom_range(33, 126)));
		endcase
	endfunction

	function automatic void add_status();
		case ($urandom_range(99)) inside
			[0:64]:  line_q.push_back(CH_A);
			[65:79]: line_q.push_back("V");
			[80:89]: add_run(CH_A, 2);
			[90:96]: line_q.push_back(8'($urandom_range(33, 126)));
			default: add_run(CH_A, $urandom_range(32, 40));
		endcase
	endfunction

	// sentence with random content; returns its length up to and including the star
	function automatic int add_sentence();
		int n_fields;
		int len;
		n_fields = ($urandom_range(99) < 85) ? 6 : $urandom_range(0, 5);
		add_text("$GPRMC,");
		for (int f = 0; f < n_fields; f++) begin
			if (f > 0) begin
				line_q.push_back(CH_COMMA);
				if ($urandom_range(99) < 12) begin
					line_q.push_back(CH_COMMA);
				end
			end
			case (f)
				0: add_digits($urandom_range(0, 6));
				1: add_status();
				2, 4: add_number();
				3: add_flag(CH_N, "S");
				default: add_flag(CH_E, "W");
			endcase
		end
		if (n_fields == 6) begin
			for (int k = $urandom_range(0, 7); k > 0; k--) begin
				line_q.push_back(CH_COMMA);
				add_digits($urandom_range(0, 6));
			end
		end
		// an occasional oversized field can run the body past its limit
		if ($urandom_range(99) < 5) begin
			line_q.push_back(CH_COMMA);
			add_digits($urandom_range(40, 90));
		end
		if ($urandom_range(99) < 4) begin
			line_q.insert($urandom_range(7, line_q.size()), CH_NUL);
		end
		line_q.push_back(CH_STAR);
		len = line_q.size();
		// checksum and line end fall in the hunt
		add_text("5C");
		line_q.push_back(CH_CR);
		line_q.push_back(8'h0A);
		return len;
	endfunction

	task automatic random_phase(input int byte_goal, input int end_goal);
		int taken;
		int ends;
		string hdr;
		taken = 0;
		ends = 0;
		hdr = "$GPRMC,";
		while (taken < byte_goal || ends < end_goal) begin
			case ($urandom_range(99)) inside
				[0:79]: begin
					taken += add_sentence();
					ends++;
				end
				[80:89]: begin
					for (int i = $urandom_range(1, 6); i > 0; i--) begin
						line_q.push_back(8'($urandom_range(0, 255)));
					end
				end
				default: begin
					// header cut short by a wrong byte
					add_text(hdr.substr(0, $urandom_range(0, 5)));
					line_q.push_back(8'($urandom_range(0, 255)));
				end
			endcase
			send_line();
		end
	endtask

	// run limit
	initial begin
		#5_000_000;
		$display("nmea_rmc_position_parser regression: fail");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed sentences
		add_text("$GPRMC,123519,A,4807.038,N,01131.000,E,022.4*");
		// two signs meet: minus with south stays positive
		add_text("$GPRMC,1,A,-12.5,S,+.00019,W*");
		// void status keeps the stored position, missing fields keep old values
		add_text("$GPRMC,2,V,1111.1,N,2222.2,E*");
		add_text("$GPRMC,3,A*");
		// blanks, saturation and an exponent that stops the read
		add_text("$GPRMC,4,A, \t99999999999.99999,N,7.5e3x,E*");
		// empty fields skipped, a second dot, a bare sign
		add_text("$GPRMC,,,5,,A,,1.2.3,NN,-,E*");
		send_line();
		// long fields
		add_text("$GPRMC,6,");
		add_run(CH_A, 35);
		add_text(",1,N,1,E*$GPRMC,7,A,");
		add_run(CH_0, 40);
		add_text("12.5,N,3,E*");
		// nul inside the body
		add_text("$GPRMC,8,A,5.5,N");
		line_q.push_back(CH_NUL);
		add_text(",6.6,E*");
		// body overflow, then fields past the last slot
		add_text("$GPRMC,9,A,1,N,2,E,");
		add_run("3", 80);
		add_text("*$GPRMC,a,A,1,N,2,E,c,d,e,f,g,h,i,j,k,9,9*");
		// star in the hunt, extreme bytes, mismatches that swallow the header
		line_q.push_back(CH_STAR);
		line_q.push_back(8'hFF);
		line_q.push_back(CH_NUL);
		add_text("$$GPRMC,1,A,1,N,1,E*$GPRM$GPRMC,0,A,0,S,0,W*");
		add_text("$GPRMC,0,A,0,S,0,W*$GPRMC,1,A,*");
		send_line();

		random_phase(250, 6);
		drain_words();

		send_idle = 73;
		recv_idle = 23;
		random_phase(250, 6);
		drain_words();

		send_idle = 0;
		recv_idle = 0;
		random_phase(250, 6);
		drain_words();

		if (fault_count == 0) begin
			$display("nmea_rmc_position_parser regression: pass");
		end else begin
			$display("nmea_rmc_position_parser regression: fail");
		end
		$finish;
	end

endmodule

`default_nettype wire

// File: nmea_rmc_position_parser.f
rtl/nrmc_pkg.sv
rtl/nrmc_result.sv
rtl/nmea_rmc_position_parser.sv
tb/sv/nmea_rmc_position_checker.sv
tb/sv/nmea_rmc_position_parser_test.sv
